// ===== hw/rtl/kljs_pkg.sv =====
// ----------------------------------------------------------------------------
// kljs_pkg
// Shared types, widths and the log2 mantissa table for the KL/JS divergence
// accumulator.
// ----------------------------------------------------------------------------
package kljs_pkg;

   localparam int PROB_BITS      = 16;
   localparam int LOG_TABLE_BITS = 8;
   localparam int FRAC_BITS      = PROB_BITS - 1;
   localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
   localparam int LOG_FRAC_BITS  = 16;
   localparam int LN2_Q16        = 45426;

   // Divergence mode register values.
   localparam logic MODE_KL = 1'b0;
   localparam logic MODE_JS = 1'b1;

   // Widths of the log unit and of the shared multiplier.
   localparam int VAL_BITS   = PROB_BITS + 1;
   localparam int EXP_BITS   = $clog2(VAL_BITS);
   localparam int LOG_BITS   = EXP_BITS + LOG_FRAC_BITS + 1;
   localparam int DIFF_BITS  = LOG_BITS + 1;
   localparam int MUL_A_BITS = DIFF_BITS + 1;
   localparam int MUL_B_BITS = (VAL_BITS + 1 > 18) ? VAL_BITS + 1 : 18;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int SUM_BITS   = 48;
   localparam int OUT_BITS   = 32;

   typedef struct packed {
      logic [PROB_BITS-1:0] prob_p;
      logic [PROB_BITS-1:0] prob_q;
      logic                 last_element;
   } kljs_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] divergence;
      logic                       support_ok;
   } kljs_rsp_type;

   typedef logic [TABLE_SIZE-1:0][LOG_FRAC_BITS-1:0] log_table_type;

   // Builds floor(65536 * log2(1 + i / TABLE_SIZE)) by repeated squaring.
   function automatic log_table_type build_log_table();
      log_table_type tbl;
      logic [63:0]   x;
      logic [15:0]   r;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         x = 64'(TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
         r = '0;
         for (int b = 15; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               r[b] = 1'b1;
               x    = x >> 1;
            end
         end
         tbl[i] = r;
      end
      return tbl;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

endpackage

// ===== hw/rtl/kl_js_divergence_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// kl_js_divergence_accumulator_top
// Accumulates Kullback-Leibler or Jensen-Shannon divergence over a stream of
// probability pairs on one shared log unit and one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Each req beat carries one element pair (prob_p, prob_q) in Q1.15 and a
//   last_element flag. The beat that carries last_element produces exactly
//   one rsp beat with the divergence in signed Q16.16 (saturated) and the
//   support_ok flag; other beats produce nothing.
//   csr_write_data selects the mode (0 = KL, 1 = JS). Write it only while
//   the block is idle; it takes effect with the next accepted beat.
// Timing:
//   req_ready is high only in the idle state, so a new element is taken
//   only once the sequencer is through with the last one. Per term the
//   sequencer runs two log lookups (one for the second JS term, which
//   reuses log2(m)) and two dependent multiplies through the single log
//   unit and the single multiplier, then one saturating add. rsp_valid
//   rises at the edge at which req_ready returns after the last element;
//   while an earlier rsp beat is still held, both wait until it is taken.
// Reset and stall:
//   Synchronous reset clears the sum, the support flag, the mode and rsp_valid.
//   A result waiting on a stalled rsp_ready does not block the next elements;
//   only the next result waits until the held rsp beat has been taken.
// ----------------------------------------------------------------------------
module kl_js_divergence_accumulator_top
   import kljs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  kljs_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output kljs_rsp_type rsp_data,
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG_M,
      ST_LOG_B,
      ST_LOG_A,
      ST_MUL_D,
      ST_MUL_T,
      ST_ACC,
      ST_FINISH
   } state_type;

   localparam logic signed [LOG_BITS-1:0] LOG_ONE = LOG_BITS'(1 << LOG_FRAC_BITS);

   state_type                     state_ff;
   logic                          mode_ff;
   logic                          item_mode_ff;
   logic [PROB_BITS-1:0]          p_ff;
   logic [PROB_BITS-1:0]          q_ff;
   logic                          last_ff;
   logic                          a_is_q_ff;
   logic                          second_ff;
   logic                          failed_ff;
   logic signed [LOG_BITS-1:0]    la_ff;
   logic signed [LOG_BITS-1:0]    lb_ff;
   logic signed [MUL_A_BITS-1:0]  t_ff;
   logic signed [PROD_BITS-1:0]   term_ff;
   logic signed [SUM_BITS-1:0]    sum_ff;
   logic                          rsp_valid_ff;
   kljs_rsp_type                  rsp_data_ff;

   logic [PROB_BITS-1:0]          a_val;
   logic [VAL_BITS-1:0]           log_arg;
   logic [EXP_BITS-1:0]           lead;
   logic [VAL_BITS-1:0]           log_norm;
   logic [LOG_TABLE_BITS-1:0]     log_idx;
   logic signed [LOG_BITS-1:0]    log_val;
   logic signed [DIFF_BITS-1:0]   diff;
   logic signed [MUL_A_BITS-1:0]  mul_a;
   logic signed [MUL_B_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0]   product;
   logic signed [PROD_BITS-1:0]   prod_t;
   logic signed [PROD_BITS-1:0]   prod_term;
   logic signed [SUM_BITS:0]      acc_wide;
   logic signed [SUM_BITS-1:0]    acc_sat_in;
   logic signed [SUM_BITS-1:0]    out_src;
   logic signed [OUT_BITS-1:0]    out_sat;
   logic                          accept;
   logic                          rsp_free;
   logic                          rsp_load;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_FINISH) && last_ff && rsp_free;
   assign a_val     = a_is_q_ff ? q_ff : p_ff;

   // Shared log2 unit: leading-one position plus a table lookup of the
   // mantissa bits just below it.
   always_comb begin
      unique case (state_ff)
         ST_LOG_M: log_arg = VAL_BITS'(p_ff) + VAL_BITS'(q_ff);
         ST_LOG_B: log_arg = VAL_BITS'(q_ff);
         default:  log_arg = VAL_BITS'(a_val);
      endcase
      lead = '0;
      for (int i = 0; i < VAL_BITS; i++) begin
         if (log_arg[i]) begin
            lead = EXP_BITS'(i);
         end
      end
      log_norm = log_arg << (EXP_BITS'(VAL_BITS - 1) - lead);
      log_idx  = log_norm[VAL_BITS-2 -: LOG_TABLE_BITS];
      log_val  = $signed({1'b0, lead, LOG_TABLE[log_idx]});
   end

   // Shared multiplier: log difference times ln2, then probability times t.
   always_comb begin
      diff = DIFF_BITS'(la_ff) - DIFF_BITS'(lb_ff);
      if (state_ff == ST_MUL_T) begin
         mul_a = t_ff;
         mul_b = $signed(MUL_B_BITS'(a_val));
      end else begin
         mul_a = MUL_A_BITS'(diff);
         mul_b = MUL_B_BITS'(LN2_Q16);
      end
      product   = mul_a * mul_b;
      prod_t    = product >>> LOG_FRAC_BITS;
      prod_term = product >>> FRAC_BITS;
   end

   // Saturating accumulate and output formatting.
   always_comb begin
      acc_wide = (SUM_BITS+1)'(sum_ff) + (SUM_BITS+1)'(term_ff);
      if (acc_wide[SUM_BITS] != acc_wide[SUM_BITS-1]) begin
         acc_sat_in = acc_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         acc_sat_in = acc_wide[SUM_BITS-1:0];
      end
      out_src = (item_mode_ff == MODE_JS) ? (sum_ff >>> 1) : sum_ff;
      if ((out_src[SUM_BITS-1:OUT_BITS-1] == '0) || (out_src[SUM_BITS-1:OUT_BITS-1] == '1)) begin
         out_sat = out_src[OUT_BITS-1:0];
      end else begin
         out_sat = out_src[SUM_BITS-1] ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                       : {1'b0, {(OUT_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_KL;
         failed_ff    <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         // A beat taken in the same cycle as a new result is replaced by it.
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  p_ff         <= req_data.prob_p;
                  q_ff         <= req_data.prob_q;
                  last_ff      <= req_data.last_element;
                  item_mode_ff <= mode_ff;
                  a_is_q_ff    <= (mode_ff == MODE_JS) && (req_data.prob_p == '0);
                  second_ff    <= (mode_ff == MODE_JS) && (req_data.prob_p != '0) &&
                                  (req_data.prob_q != '0);
                  if (mode_ff == MODE_JS) begin
                     if ((req_data.prob_p == '0) && (req_data.prob_q == '0)) begin
                        state_ff <= ST_FINISH;
                     end else begin
                        state_ff <= ST_LOG_M;
                     end
                  end else if (failed_ff || (req_data.prob_p == '0)) begin
                     state_ff <= ST_FINISH;
                  end else if (req_data.prob_q == '0) begin
                     // Missing support: the rest of this vector adds nothing.
                     failed_ff <= 1'b1;
                     state_ff  <= ST_FINISH;
                  end else begin
                     state_ff <= ST_LOG_B;
                  end
               end
            end
            ST_LOG_M: begin
               // log2(m) is log2(p + q) minus one.
               lb_ff    <= log_val - LOG_ONE;
               state_ff <= ST_LOG_A;
            end
            ST_LOG_B: begin
               lb_ff    <= log_val;
               state_ff <= ST_LOG_A;
            end
            ST_LOG_A: begin
               la_ff    <= log_val;
               state_ff <= ST_MUL_D;
            end
            ST_MUL_D: begin
               t_ff     <= MUL_A_BITS'(prod_t);
               state_ff <= ST_MUL_T;
            end
            ST_MUL_T: begin
               term_ff  <= prod_term;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               sum_ff <= acc_sat_in;
               if (second_ff) begin
                  a_is_q_ff <= 1'b1;
                  second_ff <= 1'b0;
                  state_ff  <= ST_LOG_A;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (rsp_free) begin
                  rsp_data_ff.divergence <= out_sat;
                  rsp_data_ff.support_ok <= (item_mode_ff == MODE_JS) || !failed_ff;
                  rsp_valid_ff           <= 1'b1;
                  sum_ff                 <= '0;
                  failed_ff              <= 1'b0;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/kljs_checker.sv =====
// ----------------------------------------------------------------------------
// kljs_checker
// Port-level checks for the KL/JS divergence accumulator, bound to the top.
// ----------------------------------------------------------------------------
module kljs_checker
   import kljs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input kljs_rsp_type rsp_data
);

   // A stalled result beat stays put until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed or dropped while stalled");

   // An accepted element always takes the sequencer out of the idle state, so req_ready drops.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready returned too early after an accepted beat");

   // A new result is only produced at the end of an element's processing.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp beat appeared while the block was idle");

   // Reset leaves the block idle with no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind kl_js_divergence_accumulator_top kljs_checker u_kljs_checker (.*);
